@@ hw/rtl/psf_pkg.sv @@
package psf_pkg;

  localparam int MAX_SPAN    = 64;
  localparam int SPAN_W      = 7;
  localparam int TILE_MAX    = 4096;
  localparam int TILE_W      = 13;
  localparam int SRC_W       = 12;
  localparam int BITMAP_ROWS = 8;
  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int REM_STEPS   = 16;
  localparam int REM_CNT_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HGT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLIT_OP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN    = 3'd6;

  localparam logic [1:0] KIND_BLIT  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  localparam logic [7:0] ROW_CLEAR = 8'h00;
  localparam logic [7:0] ROW_FULL  = 8'hff;

  typedef struct packed {
    logic start;
    logic load;
    logic advance;
  } psf_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic rem_done;
    logic last;
  } psf_sts_t;

endpackage

@@ hw/rtl/psf_rem.sv @@
module psf_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [16:0]          dividend,
  input  logic [psf_pkg::TILE_W-1:0]  divisor,
  output logic                        done,
  output logic [psf_pkg::SRC_W-1:0]   result
);
  import psf_pkg::*;

  logic [REM_STEPS-1:0] mag_r, mag_nxt;
  logic [TILE_W-1:0]    rem_r, rem_nxt;
  logic [TILE_W-1:0]    div_r;
  logic                 neg_r;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [16:0]          abs_val;
  logic [TILE_W:0]      trial;
  logic [TILE_W-1:0]    fixed;

  assign abs_val = dividend[16] ? 17'(-dividend) : 17'(dividend);
  assign trial   = {rem_r, mag_r[REM_STEPS-1]};

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      mag_nxt  = abs_val[REM_STEPS-1:0];
      rem_nxt  = '0;
      cnt_nxt  = REM_CNT_W'(REM_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[REM_STEPS-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = TILE_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[TILE_W-1:0];
      end
      cnt_nxt = cnt_r - REM_CNT_W'(1);
      if (cnt_r == REM_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
      neg_r <= dividend[16];
    end
  end

  // negative dividend with nonzero remainder folds back into range
  assign fixed  = (neg_r && rem_r != '0) ? TILE_W'(div_r - rem_r) : rem_r;
  assign done   = !busy_r;
  assign result = fixed[SRC_W-1:0];

endmodule

@@ hw/rtl/psf_ctrl.sv @@
module psf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  psf_pkg::psf_sts_t sts,
  output psf_pkg::psf_cmd_t cmd
);
  import psf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cmd.start   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && !sts.in_zero) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.rem_done) begin
          cmd.load  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          cmd.advance = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/psf_dp.sv @@
module psf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [psf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psf_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic signed [psf_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [psf_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [psf_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [psf_pkg::COORD_W-1:0] in_origin_y,
  input  logic [psf_pkg::SPAN_W-1:0]        in_span_width,
  input  psf_pkg::psf_cmd_t                 cmd,
  output psf_pkg::psf_sts_t                 sts,
  output logic [1:0]                        out_kind,
  output logic signed [psf_pkg::COORD_W-1:0] out_dest_x,
  output logic signed [psf_pkg::COORD_W-1:0] out_dest_y,
  output logic [psf_pkg::SRC_W-1:0]         out_source_x,
  output logic [psf_pkg::SRC_W-1:0]         out_source_y,
  output logic [psf_pkg::SPAN_W-1:0]        out_run_length,
  output logic [psf_pkg::COLOR_W-1:0]       out_color,
  output logic                              out_last
);
  import psf_pkg::*;

  logic               fill_mode_r;
  logic [TILE_W-1:0]  tile_width_r;
  logic [TILE_W-1:0]  tile_height_r;
  logic [COLOR_W-1:0] blit_op_r;
  logic [COLOR_W-1:0] fg_color_r;
  logic [COLOR_W-1:0] bg_color_r;
  logic [CFG_W-1:0]   pattern_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r   <= 1'b0;
      tile_width_r  <= TILE_W'(8);
      tile_height_r <= TILE_W'(8);
      blit_op_r     <= '0;
      fg_color_r    <= '0;
      bg_color_r    <= '0;
      pattern_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FILL_MODE:  fill_mode_r   <= cfg_wr_data[0];
        REG_TILE_WIDTH: tile_width_r  <= cfg_wr_data[TILE_W-1:0];
        REG_TILE_HGT:   tile_height_r <= cfg_wr_data[TILE_W-1:0];
        REG_BLIT_OP:    blit_op_r     <= cfg_wr_data[COLOR_W-1:0];
        REG_FG_COLOR:   fg_color_r    <= cfg_wr_data[COLOR_W-1:0];
        REG_BG_COLOR:   bg_color_r    <= cfg_wr_data[COLOR_W-1:0];
        REG_PATTERN:    pattern_r     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // clamped tile and bitmap sizes
  logic [TILE_W-1:0] tw;
  logic [TILE_W-1:0] th;
  logic [TILE_W-1:0] bh;

  always_comb begin
    priority if (tile_width_r == '0) tw = TILE_W'(1);
    else if (tile_width_r > TILE_W'(TILE_MAX)) tw = TILE_W'(TILE_MAX);
    else tw = tile_width_r;
    priority if (tile_height_r == '0) th = TILE_W'(1);
    else if (tile_height_r > TILE_W'(TILE_MAX)) th = TILE_W'(TILE_MAX);
    else th = tile_height_r;
    priority if (tile_height_r == '0) bh = TILE_W'(1);
    else if (tile_height_r > TILE_W'(BITMAP_ROWS)) bh = TILE_W'(BITMAP_ROWS);
    else bh = tile_height_r;
  end

  logic signed [16:0] x_off;
  logic signed [16:0] y_off;
  logic [TILE_W-1:0]  y_div;
  logic               rem_x_done;
  logic               rem_y_done;
  logic [SRC_W-1:0]   rem_x;
  logic [SRC_W-1:0]   rem_y;

  assign x_off = 17'(in_start_x) - 17'(in_origin_x);
  assign y_off = fill_mode_r ? 17'(in_start_y) : 17'(in_start_y) - 17'(in_origin_y);
  assign y_div = fill_mode_r ? bh : th;

  psf_rem u_rem_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (x_off),
    .divisor  (tw),
    .done     (rem_x_done),
    .result   (rem_x)
  );

  psf_rem u_rem_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (y_off),
    .divisor  (y_div),
    .done     (rem_y_done),
    .result   (rem_y)
  );

  logic [COORD_W-1:0] dx_r;
  logic [COORD_W-1:0] y_r;
  logic [SPAN_W-1:0]  left_r;
  logic [SRC_W-1:0]   xp_r;
  logic [SRC_W-1:0]   yp_r;

  logic [7:0]         bits;
  logic [TILE_W-1:0]  avail;
  logic [SPAN_W-1:0]  len;
  logic [1:0]         kind;
  logic [COLOR_W-1:0] color;
  logic               bit_set;

  assign bits    = pattern_r[{yp_r[2:0], 3'b000} +: 8];
  assign avail   = TILE_W'(tw - {1'b0, xp_r});
  assign bit_set = bits[3'd7 - dx_r[2:0]];

  always_comb begin
    if (!fill_mode_r) begin
      kind  = KIND_BLIT;
      color = blit_op_r;
      len   = (avail < TILE_W'(left_r)) ? avail[SPAN_W-1:0] : left_r;
    end else if (bits == ROW_CLEAR) begin
      kind  = KIND_RUN;
      color = bg_color_r;
      len   = left_r;
    end else if (bits == ROW_FULL) begin
      kind  = KIND_RUN;
      color = fg_color_r;
      len   = left_r;
    end else begin
      kind  = KIND_PIXEL;
      color = bit_set ? fg_color_r : bg_color_r;
      len   = SPAN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dx_r   <= in_start_x;
      y_r    <= in_start_y;
      left_r <= (in_span_width > SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN) : in_span_width;
    end else if (cmd.advance) begin
      dx_r   <= dx_r + COORD_W'(len);
      left_r <= left_r - len;
    end
    if (cmd.load) begin
      xp_r <= rem_x;
      yp_r <= rem_y;
    end else if (cmd.advance) begin
      xp_r <= '0;
    end
  end

  assign sts.in_zero  = (in_span_width == '0);
  assign sts.rem_done = rem_x_done && rem_y_done;
  assign sts.last     = (left_r == len);

  assign out_kind       = kind;
  assign out_dest_x     = dx_r;
  assign out_dest_y     = y_r;
  assign out_source_x   = fill_mode_r ? '0 : xp_r;
  assign out_source_y   = fill_mode_r ? '0 : yp_r;
  assign out_run_length = len;
  assign out_color      = color;
  assign out_last       = sts.last;

endmodule

@@ hw/rtl/pattern_span_fill_top.sv @@
// Pattern span filler: each accepted span is turned into blit chunks (pixmap
// mode) or a solid run / per-pixel commands (bitmap mode), one command per
// cycle on the out channel while out_stall is low, with last marking the
// final one. One span is processed at a time: an item is accepted, the
// bit-serial remainder units find its tile phase, the phase is loaded,
// then the commands (up to 64) are emitted. A span of zero width is
// accepted and produces nothing. Configuration may be written only while
// no span is in progress.
module pattern_span_fill_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [psf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psf_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [psf_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [psf_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [psf_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [psf_pkg::COORD_W-1:0] in_origin_y,
  input  logic [psf_pkg::SPAN_W-1:0]        in_span_width,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_kind,
  output logic signed [psf_pkg::COORD_W-1:0] out_dest_x,
  output logic signed [psf_pkg::COORD_W-1:0] out_dest_y,
  output logic [psf_pkg::SRC_W-1:0]         out_source_x,
  output logic [psf_pkg::SRC_W-1:0]         out_source_y,
  output logic [psf_pkg::SPAN_W-1:0]        out_run_length,
  output logic [psf_pkg::COLOR_W-1:0]       out_color,
  output logic                              out_last
);
  import psf_pkg::*;

  psf_cmd_t cmd;
  psf_sts_t sts;

  psf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  psf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_span_width  (in_span_width),
    .cmd            (cmd),
    .sts            (sts),
    .out_kind       (out_kind),
    .out_dest_x     (out_dest_x),
    .out_dest_y     (out_dest_y),
    .out_source_x   (out_source_x),
    .out_source_y   (out_source_y),
    .out_run_length (out_run_length),
    .out_color      (out_color),
    .out_last       (out_last)
  );

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("command offered while input side is open");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("span ended without last");

  a_pixel_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PIXEL) |-> (out_run_length == SPAN_W'(1)))
    else $error("pixel command with length other than one");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_length != '0))
    else $error("zero length command");

endmodule

@@ bench/pattern_span_fill_top_tb.sv @@
`timescale 1ns / 100ps

module pattern_span_fill_top_tb;
  import psf_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SPAN_W-1:0]  span_width;
  } span_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [SRC_W-1:0]   source_x;
    logic [SRC_W-1:0]   source_y;
    logic [SPAN_W-1:0]  run_length;
    logic [COLOR_W-1:0] color;
    logic               last;
  } draw_cmd_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wr_data;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_start_x = '0;
  logic signed [COORD_W-1:0] in_start_y = '0;
  logic signed [COORD_W-1:0] in_origin_x = '0;
  logic signed [COORD_W-1:0] in_origin_y = '0;
  logic [SPAN_W-1:0] in_span_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic signed [COORD_W-1:0] out_dest_x;
  logic signed [COORD_W-1:0] out_dest_y;
  logic [SRC_W-1:0] out_source_x;
  logic [SRC_W-1:0] out_source_y;
  logic [SPAN_W-1:0] out_run_length;
  logic [COLOR_W-1:0] out_color;
  logic out_last;

  // shadow copy of the block's registers
  logic              fill_mode_reg = 1'b0;
  logic [TILE_W-1:0] tile_width_reg = 13'd8;
  logic [TILE_W-1:0] tile_height_reg = 13'd8;
  logic [31:0]       blit_op_reg = '0;
  logic [31:0]       fg_color_reg = '0;
  logic [31:0]       bg_color_reg = '0;
  logic [63:0]       pattern_reg = '0;

  span_t     span_backlog[$];
  draw_cmd_t due_cmds[$];
  int        spans_queued = 0;
  int        spans_taken = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;
  span_t     next_span;
  draw_cmd_t seen_cmd;
  draw_cmd_t want_cmd;

  pattern_span_fill_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int size_limit(logic [TILE_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int floor_mod(int a, int m);
    int r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  task automatic push_cmd(logic [1:0] kind, int dx, int dy, int sx, int sy, int len,
                          logic [31:0] color, bit last);
    draw_cmd_t c;
    c.kind = kind;
    c.dest_x = 16'(dx);
    c.dest_y = 16'(dy);
    c.source_x = 12'(sx);
    c.source_y = 12'(sy);
    c.run_length = 7'(len);
    c.color = color;
    c.last = last;
    due_cmds.push_back(c);
  endtask

  task automatic derive_span_cmds(span_t s);
    int x, y, ox, oy, width, tw, th, xp, yp, chunk, dx, rows, row;
    logic [7:0] bits, mask;
    x = $signed(s.start_x);
    y = $signed(s.start_y);
    ox = $signed(s.origin_x);
    oy = $signed(s.origin_y);
    width = int'(s.span_width);
    if (width > MAX_SPAN) width = MAX_SPAN;
    if (width == 0) return;
    if (!fill_mode_reg) begin
      tw = size_limit(tile_width_reg, TILE_MAX);
      th = size_limit(tile_height_reg, TILE_MAX);
      xp = floor_mod(x - ox, tw);
      yp = floor_mod(y - oy, th);
      chunk = tw - xp;
      dx = x;
      while (width > 0) begin
        if (chunk > width) chunk = width;
        width -= chunk;
        push_cmd(KIND_BLIT, dx, y, xp, yp, chunk, blit_op_reg, width == 0);
        dx += chunk;
        xp = 0;
        chunk = tw;
      end
    end else begin
      rows = size_limit(tile_height_reg, BITMAP_ROWS);
      row = floor_mod(y, rows);
      bits = pattern_reg[8*row +: 8];
      if (bits == ROW_CLEAR) begin
        push_cmd(KIND_RUN, x, y, 0, 0, width, bg_color_reg, 1'b1);
      end else if (bits == ROW_FULL) begin
        push_cmd(KIND_RUN, x, y, 0, 0, width, fg_color_reg, 1'b1);
      end else begin
        mask = 8'h80 >> x[2:0];
        for (int i = 0; i < width; i++) begin
          push_cmd(KIND_PIXEL, x + i, y, 0, 0, 1,
                   ((bits & mask) != 0) ? fg_color_reg : bg_color_reg, i == width - 1);
          mask = (mask == 8'h01) ? 8'h80 : (mask >> 1);
        end
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_FILL_MODE:  fill_mode_reg = val[0];
      REG_TILE_WIDTH: tile_width_reg = val[TILE_W-1:0];
      REG_TILE_HGT:   tile_height_reg = val[TILE_W-1:0];
      REG_BLIT_OP:    blit_op_reg = val[31:0];
      REG_FG_COLOR:   fg_color_reg = val[31:0];
      REG_BG_COLOR:   bg_color_reg = val[31:0];
      REG_PATTERN:    pattern_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic config_all(logic mode, logic [TILE_W-1:0] tw, logic [TILE_W-1:0] th,
                            logic [31:0] op, logic [31:0] fg, logic [31:0] bg,
                            logic [63:0] pat);
    write_reg(REG_FILL_MODE, CFG_W'(mode));
    write_reg(REG_TILE_WIDTH, CFG_W'(tw));
    write_reg(REG_TILE_HGT, CFG_W'(th));
    write_reg(REG_BLIT_OP, CFG_W'(op));
    write_reg(REG_FG_COLOR, CFG_W'(fg));
    write_reg(REG_BG_COLOR, CFG_W'(bg));
    write_reg(REG_PATTERN, pat);
  endtask

  task automatic add_span(logic [15:0] x, logic [15:0] y, logic [15:0] ox,
                          logic [15:0] oy, logic [6:0] w);
    span_backlog.push_back('{x, y, ox, oy, w});
    spans_queued++;
  endtask

  task automatic finish_phase();
    while (spans_taken != spans_queued || due_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TILE_W-1:0] pick_tile_size();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'($urandom_range(1, 8));
      2: return 13'($urandom_range(1, 70));
      3: return 13'd8191;
      4: return 13'd4096;
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_setup();
    logic [63:0] pat;
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(0, 3))
        0: pat[8*b +: 8] = ROW_CLEAR;
        1: pat[8*b +: 8] = ROW_FULL;
        default: pat[8*b +: 8] = 8'($urandom());
      endcase
    end
    config_all(1'($urandom()), pick_tile_size(), pick_tile_size(), pick_color(),
               pick_color(), pick_color(), pat);
  endtask

  task automatic add_random_span();
    logic [6:0] w;
    case ($urandom_range(0, 9))
      0: w = 7'd0;
      1: w = 7'($urandom_range(65, 127));
      2: w = 7'($urandom_range(1, 4));
      default: w = 7'($urandom_range(1, 64));
    endcase
    add_span(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()), w);
  endtask

  // input side: one transfer per accepted span
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        derive_span_cmds('{in_start_x, in_start_y, in_origin_x, in_origin_y, in_span_width});
        spans_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (span_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
          next_span = span_backlog.pop_front();
          in_valid <= 1'b1;
          in_start_x <= next_span.start_x;
          in_start_y <= next_span.start_y;
          in_origin_x <= next_span.origin_x;
          in_origin_y <= next_span.origin_y;
          in_span_width <= next_span.span_width;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // output side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_cmd = '{out_kind, out_dest_x, out_dest_y, out_source_x, out_source_y,
                   out_run_length, out_color, out_last};
      if (due_cmds.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %0h", $time, seen_cmd);
        error_count++;
      end else begin
        want_cmd = due_cmds.pop_front();
        check_field("kind", 64'(want_cmd.kind), 64'(seen_cmd.kind));
        check_field("dest_x", 64'(want_cmd.dest_x), 64'(seen_cmd.dest_x));
        check_field("dest_y", 64'(want_cmd.dest_y), 64'(seen_cmd.dest_y));
        check_field("source_x", 64'(want_cmd.source_x), 64'(seen_cmd.source_x));
        check_field("source_y", 64'(want_cmd.source_y), 64'(seen_cmd.source_y));
        check_field("run_length", 64'(want_cmd.run_length), 64'(seen_cmd.run_length));
        check_field("color", 64'(want_cmd.color), 64'(seen_cmd.color));
        check_field("last", 64'(want_cmd.last), 64'(seen_cmd.last));
      end
    end
    out_stall <= !quiet && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 8x8 pixmap tile
    add_span(16'd0, 16'd0, 16'd0, 16'd0, 7'd1);
    add_span(16'd5, 16'd3, 16'd0, 16'd0, 7'd64);
    add_span(16'd9, 16'd9, 16'd0, 16'd0, 7'd0);
    add_span(16'hffff, 16'hffff, 16'd0, 16'd0, 7'd127);
    add_span(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 7'd20);
    add_span(16'h7ffc, 16'h7fff, 16'h8000, 16'h8000, 7'd64);
    finish_phase();

    // zero tile size acts as one pixel
    config_all(1'b0, 13'd0, 13'd0, 32'hffff_ffff, 32'h0, 32'h0, 64'h0);
    add_span(16'd3, 16'hfffe, 16'd100, 16'd7, 7'd64);
    finish_phase();

    // oversized tile saturates
    config_all(1'b0, 13'd8191, 13'd8191, 32'h5a5a_a5a5, 32'hffff_ffff, 32'h0,
               64'hffff_ffff_ffff_ffff);
    add_span(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 7'd64);
    add_span(16'h8000, 16'h0000, 16'h7fff, 16'h0001, 7'd33);
    finish_phase();
    config_all(1'b0, 13'd13, 13'd4096, 32'h0000_0001, 32'h0, 32'hffff_ffff, 64'h0);
    add_span(16'hfff0, 16'h0123, 16'h0005, 16'hf000, 7'd64);
    finish_phase();

    // bitmap pattern: rows of clear, full and mixed bits
    config_all(1'b1, 13'd8, 13'd8, 32'h0, 32'hffff_ffff, 32'h0,
               64'h7e81_3ca5_00ff_0180);
    add_span(16'd0, 16'd2, 16'd0, 16'd0, 7'd64);
    add_span(16'd7, 16'd3, 16'd0, 16'd0, 7'd127);
    add_span(16'd0, 16'd0, 16'd0, 16'd0, 7'd8);
    add_span(16'd5, 16'd1, 16'd0, 16'd0, 7'd12);
    add_span(16'hfffd, 16'hffff, 16'h1234, 16'h4321, 7'd10);
    add_span(16'h7ffe, 16'h8000, 16'd0, 16'd0, 7'd6);
    add_span(16'd1, 16'd4, 16'd0, 16'd0, 7'd0);
    finish_phase();

    config_all(1'b1, 13'd1, 13'd0, 32'hffff_ffff, 32'h1234_5678, 32'hffff_ffff,
               64'hff00_ff00_ff00_ff5a);
    add_span(16'd3, 16'd5, 16'd0, 16'd0, 7'd9);
    finish_phase();
    config_all(1'b1, 13'd4096, 13'd3, 32'h0, 32'h0, 32'hcafe_f00d,
               64'h0000_0000_00ff_a500);
    add_span(16'd2, 16'hfffc, 16'd0, 16'd0, 7'd11);
    add_span(16'd2, 16'd6, 16'd0, 16'd0, 7'd5);
    finish_phase();
    config_all(1'b1, 13'd8191, 13'd8191, 32'h0, 32'hffff_ffff, 32'h0,
               64'h01ff_ffff_ffff_ffff);
    add_span(16'd4, 16'd7, 16'd0, 16'd0, 7'd16);
    finish_phase();

    for (int p = 0; p < 6; p++) begin
      random_setup();
      quiet = (p == 2);
      repeat (17) add_random_span();
      finish_phase();
    end
    quiet = 1'b0;

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
